/* sv/adnv_pkg.sv */
// ----------------------------------------------------------------------------
// adnv_pkg
// Shared types and constants for the automatic day/night vote block.
// ----------------------------------------------------------------------------
package adnv_pkg;

  localparam int unsigned GainW  = 16;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned CntW   = 4;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned MCodeW = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CntW-1:0] CntMax = 4'd15;

  // decided mode
  localparam logic [ModeW-1:0] MODE_DAY      = 2'd0;
  localparam logic [ModeW-1:0] MODE_LOWLIGHT = 2'd1;
  localparam logic [ModeW-1:0] MODE_NIGHT    = 2'd2;

  // image mode codes to set
  localparam logic [MCodeW-1:0] CODE_DAY      = 4'd2;
  localparam logic [MCodeW-1:0] CODE_LOWLIGHT = 4'd8;
  localparam logic [MCodeW-1:0] CODE_NIGHT    = 4'd11;

  // current code bands
  localparam logic [CodeW-1:0] DAY_CODE_LO = 8'd1;
  localparam logic [CodeW-1:0] DAY_CODE_HI = 8'd4;
  localparam logic [CodeW-1:0] LOW_CODE_LO = 8'd5;
  localparam logic [CodeW-1:0] LOW_CODE_HI = 8'd8;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_THR_DAY_TO_LOW   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_THR_LOW_TO_NIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_THR_NIGHT_TO_DAY = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_THR_LOW_TO_DAY   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_LEN       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_VOTE_MIN         = 3'd5;

  // register reset values
  localparam logic [GainW-1:0] RST_THR_DAY_TO_LOW   = 16'd2048;
  localparam logic [GainW-1:0] RST_THR_LOW_TO_NIGHT = 16'd3072;
  localparam logic [GainW-1:0] RST_THR_NIGHT_TO_DAY = 16'd512;
  localparam logic [GainW-1:0] RST_THR_LOW_TO_DAY   = 16'd768;
  localparam logic [CntW-1:0]  RST_WINDOW_LEN       = 4'd8;
  localparam logic [CntW-1:0]  RST_VOTE_MIN         = 4'd5;

  typedef struct packed {
    logic             auto_enable;
    logic [GainW-1:0] gain_q88;
    logic [CodeW-1:0] current_code;
  } in_t;

  typedef struct packed {
    logic [ModeW-1:0]  target_mode;
    logic [MCodeW-1:0] mode_code;
  } out_t;

  typedef struct packed {
    logic [GainW-1:0] thr_day_to_lowlight;
    logic [GainW-1:0] thr_lowlight_to_night;
    logic [GainW-1:0] thr_night_to_day;
    logic [GainW-1:0] thr_lowlight_to_day;
    logic [CntW-1:0]  window_len;
    logic [CntW-1:0]  vote_min;
  } cfg_t;

  // saturating increment of a vote or sample counter
  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] c);
    logic [CntW-1:0] r;
    r = (c == CntMax) ? CntMax : c + 1'b1;
    return r;
  endfunction

endpackage

/* sv/adnv_core.sv */
// ----------------------------------------------------------------------------
// adnv_core
// Vote counters, band compare and window decision for one sample per cycle while fire is high.
// ----------------------------------------------------------------------------
module adnv_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  adnv_pkg::in_t item,
  input  adnv_pkg::cfg_t cfg,
  output logic          res_valid,
  output adnv_pkg::out_t res
);

  logic [adnv_pkg::CntW-1:0] sample_count_r, sample_count_nxt;
  logic [adnv_pkg::CntW-1:0] day_votes_r, day_votes_nxt;
  logic [adnv_pkg::CntW-1:0] low_votes_r, low_votes_nxt;
  logic [adnv_pkg::CntW-1:0] night_votes_r, night_votes_nxt;

  logic band_day, band_low;
  logic vote_day, vote_low, vote_night;
  logic [adnv_pkg::CntW-1:0] day_inc, low_inc, night_inc, smp_inc;
  logic close_win, active;

  // band select from current mode code
  always_comb begin
    band_day = (item.current_code inside {[adnv_pkg::DAY_CODE_LO:adnv_pkg::DAY_CODE_HI]});
    band_low = (item.current_code inside {[adnv_pkg::LOW_CODE_LO:adnv_pkg::LOW_CODE_HI]});
  end

  // strict gain compares against the band thresholds
  always_comb begin
    vote_day   = 1'b0;
    vote_low   = 1'b0;
    vote_night = 1'b0;
    if (band_day) begin
      vote_low = item.gain_q88 > cfg.thr_day_to_lowlight;
    end else if (band_low) begin
      vote_night = item.gain_q88 > cfg.thr_lowlight_to_night;
      vote_day   = !vote_night && (item.gain_q88 < cfg.thr_lowlight_to_day);
    end else begin
      vote_day = item.gain_q88 < cfg.thr_night_to_day;
    end
  end

  // counters after this sample
  always_comb begin
    day_inc   = vote_day   ? adnv_pkg::bump(day_votes_r)   : day_votes_r;
    low_inc   = vote_low   ? adnv_pkg::bump(low_votes_r)   : low_votes_r;
    night_inc = vote_night ? adnv_pkg::bump(night_votes_r) : night_votes_r;
    smp_inc   = adnv_pkg::bump(sample_count_r);
    active    = fire && item.auto_enable;
    close_win = smp_inc >= cfg.window_len;
  end

  // window decision, day first then low light then night
  always_comb begin
    res_valid       = 1'b0;
    res.target_mode = adnv_pkg::MODE_DAY;
    res.mode_code   = adnv_pkg::CODE_DAY;
    if (active && close_win) begin
      if (day_inc >= cfg.vote_min) begin
        res_valid = 1'b1;
      end else if (low_inc >= cfg.vote_min) begin
        res_valid       = 1'b1;
        res.target_mode = adnv_pkg::MODE_LOWLIGHT;
        res.mode_code   = adnv_pkg::CODE_LOWLIGHT;
      end else if (night_inc >= cfg.vote_min) begin
        res_valid       = 1'b1;
        res.target_mode = adnv_pkg::MODE_NIGHT;
        res.mode_code   = adnv_pkg::CODE_NIGHT;
      end
    end
  end

  // next counter state
  always_comb begin
    sample_count_nxt = sample_count_r;
    day_votes_nxt    = day_votes_r;
    low_votes_nxt    = low_votes_r;
    night_votes_nxt  = night_votes_r;
    if (active) begin
      if (close_win) begin
        sample_count_nxt = '0;
        day_votes_nxt    = '0;
        low_votes_nxt    = '0;
        night_votes_nxt  = '0;
      end else begin
        sample_count_nxt = smp_inc;
        day_votes_nxt    = day_inc;
        low_votes_nxt    = low_inc;
        night_votes_nxt  = night_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= '0;
      day_votes_r    <= '0;
      low_votes_r    <= '0;
      night_votes_r  <= '0;
    end else begin
      sample_count_r <= sample_count_nxt;
      day_votes_r    <= day_votes_nxt;
      low_votes_r    <= low_votes_nxt;
      night_votes_r  <= night_votes_nxt;
    end
  end

  // a closed window leaves every counter clear
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    active && close_win |=> sample_count_r == '0 && day_votes_r == '0 &&
                            low_votes_r == '0 && night_votes_r == '0)
    else $error("counters not cleared at window end");

  // an ignored tick leaves the counters alone
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !active |=> $stable(sample_count_r) && $stable(day_votes_r) &&
                $stable(low_votes_r) && $stable(night_votes_r))
    else $error("counters moved without an enabled sample");

  // votes in a window never pass the sample count
  a_votes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    day_votes_r + low_votes_r + night_votes_r <= {1'b0, sample_count_r})
    else $error("more votes than samples");

endmodule

/* sv/auto_day_night_vote.sv */
// ----------------------------------------------------------------------------
// auto_day_night_vote
// Automatic day/night mode voting over a window of gain samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one tick transaction per accept (in_valid high, in_stall low),
//           carrying auto enable, Q8.8 gain and the current mode code.
//   out_* : one transaction per closed window that has a winner, carrying
//           the target mode and the mode code to set.
//   cfg_* : register writes (valid/ready, ready always high); write only
//           while the block is idle. Index 0..5 as thresholds, window
//           length and vote minimum; other indexes are ignored.
// Timing: a tick is held in the input register, where compare and
//   counter update happen, and its result is written into a two-entry
//   output queue, whose count register drives out_valid.
//   One tick per cycle is taken as long as the receiver keeps up; the
//   output queue absorbs two stalled results before in_stall rises.
// Reset (rst_n low, synchronous): registers return to their defaults,
//   all counters clear and the output queue empties.
// Receiver stall: results wait in the queue; once it is full the input
//   register holds its tick and in_stall goes high.
// ----------------------------------------------------------------------------
module auto_day_night_vote (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  adnv_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output adnv_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [adnv_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [adnv_pkg::CfgDatW-1:0]      cfg_data
);

  adnv_pkg::cfg_t cfg_r;

  logic          s1_valid_r;
  adnv_pkg::in_t s1_data_r;

  adnv_pkg::out_t q_mem_r [2];
  logic           q_wr_r, q_rd_r;
  logic [1:0]     q_cnt_r;
  logic           q_full;

  logic           in_fire, s1_fire, q_push, q_pop;
  logic           res_valid;
  adnv_pkg::out_t res;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr_day_to_lowlight   <= adnv_pkg::RST_THR_DAY_TO_LOW;
      cfg_r.thr_lowlight_to_night <= adnv_pkg::RST_THR_LOW_TO_NIGHT;
      cfg_r.thr_night_to_day      <= adnv_pkg::RST_THR_NIGHT_TO_DAY;
      cfg_r.thr_lowlight_to_day   <= adnv_pkg::RST_THR_LOW_TO_DAY;
      cfg_r.window_len            <= adnv_pkg::RST_WINDOW_LEN;
      cfg_r.vote_min              <= adnv_pkg::RST_VOTE_MIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        adnv_pkg::REG_THR_DAY_TO_LOW:   cfg_r.thr_day_to_lowlight   <= cfg_data;
        adnv_pkg::REG_THR_LOW_TO_NIGHT: cfg_r.thr_lowlight_to_night <= cfg_data;
        adnv_pkg::REG_THR_NIGHT_TO_DAY: cfg_r.thr_night_to_day      <= cfg_data;
        adnv_pkg::REG_THR_LOW_TO_DAY:   cfg_r.thr_lowlight_to_day   <= cfg_data;
        adnv_pkg::REG_WINDOW_LEN:       cfg_r.window_len <= cfg_data[adnv_pkg::CntW-1:0];
        adnv_pkg::REG_VOTE_MIN:         cfg_r.vote_min   <= cfg_data[adnv_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // handshake control
  assign q_full   = q_cnt_r[1];
  assign in_stall = s1_valid_r && q_full;
  assign in_fire  = in_valid && !in_stall;
  assign s1_fire  = s1_valid_r && !q_full;
  assign q_push   = res_valid;
  assign q_pop    = out_valid && !out_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
  end

  // vote logic and counters
  adnv_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_fire),
    .item      (s1_data_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      if (q_push) begin
        q_wr_r <= !q_wr_r;
      end
      if (q_pop) begin
        q_rd_r <= !q_rd_r;
      end
      case ({q_push, q_pop})
        2'b10:   q_cnt_r <= q_cnt_r + 2'd1;
        2'b01:   q_cnt_r <= q_cnt_r - 2'd1;
        default: q_cnt_r <= q_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[q_wr_r] <= res;
    end
  end

  assign out_valid = (q_cnt_r != 2'd0);
  assign out_data  = q_mem_r[q_rd_r];

  // queue never holds more than two results
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'd2)
    else $error("result queue overflow");

  // a result is only written when there is room
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full result queue");

  // stall only while a tick waits behind a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && q_cnt_r == 2'd2)
    else $error("input stalled without cause");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the automatic day/night vote block. A queue-fed
// driver sends tick transactions with random idle bursts, a scoreboard
// predicts each window's decision from its own copy of the vote counters
// and the register file, and a monitor with random stall bursts checks
// every result transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CycleLimit = 300000;
  localparam int TicksPerPhase = 100;
  localparam int RandPhases = 10;

  // indexes outside the register file, writes there must be ignored
  localparam logic [adnv_pkg::CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [adnv_pkg::CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {THEME_DAY, THEME_LOW, THEME_NIGHT, THEME_NOISE} theme_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  adnv_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  adnv_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [adnv_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [adnv_pkg::CfgDatW-1:0] cfg_data = '0;

  auto_day_night_vote DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  adnv_pkg::in_t tick_q[$];
  adnv_pkg::out_t decision_q[$];
  adnv_pkg::cfg_t shadow;
  logic [adnv_pkg::CntW-1:0] smp_cnt, day_cnt, low_cnt, night_cnt;
  int idle_pct = 20;
  int gap_left = 0;
  int stall_left = 0;
  int fails = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("auto_day_night_vote regression: fail");
      $finish;
    end
  end

  function automatic logic [adnv_pkg::CntW-1:0] sat_inc(input logic [adnv_pkg::CntW-1:0] c);
    return (c == 4'hF) ? c : c + 4'd1;
  endfunction

  // vote on one accepted tick, queue the decision when a window closes
  task automatic tally_vote(input adnv_pkg::in_t t);
    adnv_pkg::out_t d;
    logic won;
    if (!t.auto_enable) return;
    if (t.current_code >= adnv_pkg::DAY_CODE_LO &&
        t.current_code <= adnv_pkg::DAY_CODE_HI) begin
      if (t.gain_q88 > shadow.thr_day_to_lowlight) low_cnt = sat_inc(low_cnt);
    end else if (t.current_code >= adnv_pkg::LOW_CODE_LO &&
                 t.current_code <= adnv_pkg::LOW_CODE_HI) begin
      // night test first, day only when no night vote
      if (t.gain_q88 > shadow.thr_lowlight_to_night) night_cnt = sat_inc(night_cnt);
      else if (t.gain_q88 < shadow.thr_lowlight_to_day) day_cnt = sat_inc(day_cnt);
    end else if (t.gain_q88 < shadow.thr_night_to_day) begin
      day_cnt = sat_inc(day_cnt);
    end
    smp_cnt = sat_inc(smp_cnt);
    if (smp_cnt >= shadow.window_len) begin
      won = 1'b1;
      if (day_cnt >= shadow.vote_min) begin
        d.target_mode = adnv_pkg::MODE_DAY;
        d.mode_code = adnv_pkg::CODE_DAY;
      end else if (low_cnt >= shadow.vote_min) begin
        d.target_mode = adnv_pkg::MODE_LOWLIGHT;
        d.mode_code = adnv_pkg::CODE_LOWLIGHT;
      end else if (night_cnt >= shadow.vote_min) begin
        d.target_mode = adnv_pkg::MODE_NIGHT;
        d.mode_code = adnv_pkg::CODE_NIGHT;
      end else begin
        won = 1'b0;
      end
      if (won) decision_q.push_back(d);
      // counters clear at every window end
      smp_cnt = '0;
      day_cnt = '0;
      low_cnt = '0;
      night_cnt = '0;
    end
  endtask

  // register shadow follows every accepted write
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow.thr_day_to_lowlight = adnv_pkg::RST_THR_DAY_TO_LOW;
      shadow.thr_lowlight_to_night = adnv_pkg::RST_THR_LOW_TO_NIGHT;
      shadow.thr_night_to_day = adnv_pkg::RST_THR_NIGHT_TO_DAY;
      shadow.thr_lowlight_to_day = adnv_pkg::RST_THR_LOW_TO_DAY;
      shadow.window_len = adnv_pkg::RST_WINDOW_LEN;
      shadow.vote_min = adnv_pkg::RST_VOTE_MIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        adnv_pkg::REG_THR_DAY_TO_LOW:   shadow.thr_day_to_lowlight = cfg_data;
        adnv_pkg::REG_THR_LOW_TO_NIGHT: shadow.thr_lowlight_to_night = cfg_data;
        adnv_pkg::REG_THR_NIGHT_TO_DAY: shadow.thr_night_to_day = cfg_data;
        adnv_pkg::REG_THR_LOW_TO_DAY:   shadow.thr_lowlight_to_day = cfg_data;
        adnv_pkg::REG_WINDOW_LEN:       shadow.window_len = cfg_data[adnv_pkg::CntW-1:0];
        adnv_pkg::REG_VOTE_MIN:         shadow.vote_min = cfg_data[adnv_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  // tick driver: predict on accept, then present the next transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      smp_cnt = '0;
      day_cnt = '0;
      low_cnt = '0;
      night_cnt = '0;
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) tally_vote(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= tick_q.pop_front();
        end
      end
    end
  end

  // result monitor with random receiver stalls
  always @(posedge clk) begin
    adnv_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decision_q.size() == 0) begin
          $error("unexpected result: target_mode %0d mode_code %0d",
                 out_data.target_mode, out_data.mode_code);
          fails++;
        end else begin
          want = decision_q.pop_front();
          if (out_data.target_mode !== want.target_mode) begin
            $error("target_mode: expected %0d, got %0d", want.target_mode,
                   out_data.target_mode);
            fails++;
          end
          if (out_data.mode_code !== want.mode_code) begin
            $error("mode_code: expected %0d, got %0d", want.mode_code,
                   out_data.mode_code);
            fails++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one register write transaction, returns at the following falling edge
  task automatic write_reg(input logic [adnv_pkg::CfgIdxW-1:0] idx,
                           input logic [adnv_pkg::CfgDatW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait for all ticks accepted and all decisions seen, then let the pipe empty
  task automatic settle();
    int waited = 0;
    do @(negedge clk); while (tick_q.size() != 0 || in_valid);
    while (decision_q.size() != 0 && waited < 500) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
  endtask

  function automatic void push_tick(input logic en, input logic [adnv_pkg::GainW-1:0] gain,
                                    input logic [adnv_pkg::CodeW-1:0] code);
    adnv_pkg::in_t t;
    t.auto_enable = en;
    t.gain_q88 = gain;
    t.current_code = code;
    tick_q.push_back(t);
  endfunction

  function automatic logic [adnv_pkg::GainW-1:0] gain_above(
      input logic [adnv_pkg::GainW-1:0] thr);
    if (thr == 16'hFFFF) return thr;
    case ($urandom_range(0, 2))
      0: return thr + 16'd1;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(thr + 1, 65535));
    endcase
  endfunction

  function automatic logic [adnv_pkg::GainW-1:0] gain_below(
      input logic [adnv_pkg::GainW-1:0] thr);
    if (thr == 16'h0000) return thr;
    case ($urandom_range(0, 2))
      0: return thr - 16'd1;
      1: return 16'h0000;
      default: return 16'($urandom_range(0, thr - 1));
    endcase
  endfunction

  function automatic logic [adnv_pkg::CodeW-1:0] night_code();
    return ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(9, 255));
  endfunction

  function automatic logic [adnv_pkg::GainW-1:0] pick_thr();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // enabled tick aimed at one vote, or noise
  function automatic adnv_pkg::in_t rand_tick(input theme_t theme);
    adnv_pkg::in_t t;
    t.auto_enable = 1'b1;
    case (theme)
      THEME_DAY: begin
        if ($urandom_range(0, 1) == 0) begin
          t.current_code = 8'($urandom_range(5, 8));
          t.gain_q88 = gain_below(shadow.thr_lowlight_to_day);
        end else begin
          t.current_code = night_code();
          t.gain_q88 = gain_below(shadow.thr_night_to_day);
        end
      end
      THEME_LOW: begin
        t.current_code = 8'($urandom_range(1, 4));
        t.gain_q88 = gain_above(shadow.thr_day_to_lowlight);
      end
      THEME_NIGHT: begin
        t.current_code = 8'($urandom_range(5, 8));
        t.gain_q88 = gain_above(shadow.thr_lowlight_to_night);
      end
      default: begin
        t.current_code = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
          0: t.gain_q88 = shadow.thr_day_to_lowlight;
          1: t.gain_q88 = shadow.thr_lowlight_to_night;
          2: t.gain_q88 = shadow.thr_night_to_day;
          3: t.gain_q88 = shadow.thr_lowlight_to_day;
          default: t.gain_q88 = 16'($urandom);
        endcase
      end
    endcase
    return t;
  endfunction

  // stimulus sequence
  initial begin
    int enabled;
    int p;
    int k;
    theme_t theme;
    logic [adnv_pkg::CntW-1:0] wlen;
    logic [adnv_pkg::CntW-1:0] vmin;
    adnv_pkg::in_t t;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset thresholds: five low-light votes, boundary gains, ignored tick
    push_tick(1'b0, 16'hFFFF, 8'd1);
    push_tick(1'b1, 16'd2049, 8'd1);
    push_tick(1'b1, 16'hFFFF, 8'd4);
    push_tick(1'b1, 16'd2049, 8'd2);
    push_tick(1'b1, 16'd4000, 8'd3);
    push_tick(1'b1, 16'd2049, 8'd1);
    push_tick(1'b1, 16'd2048, 8'd4);
    push_tick(1'b1, 16'd511, 8'd0);
    push_tick(1'b1, 16'd3073, 8'd8);
    settle();

    // short windows: night win, day win, window with no winner
    write_reg(adnv_pkg::REG_WINDOW_LEN, 16'd3);
    write_reg(adnv_pkg::REG_VOTE_MIN, 16'd2);
    push_tick(1'b1, 16'hFFFF, 8'd5);
    push_tick(1'b1, 16'd3073, 8'd7);
    push_tick(1'b1, 16'd0, 8'd8);
    push_tick(1'b1, 16'd0, 8'd0);
    push_tick(1'b1, 16'd511, 8'd255);
    push_tick(1'b1, 16'd767, 8'd6);
    push_tick(1'b1, 16'd0, 8'd4);
    push_tick(1'b1, 16'd512, 8'd9);
    push_tick(1'b1, 16'd1000, 8'd6);
    settle();

    // window length lowered while a window is open
    write_reg(adnv_pkg::REG_WINDOW_LEN, 16'd8);
    push_tick(1'b1, 16'hFFFF, 8'd5);
    push_tick(1'b1, 16'hFFFF, 8'd200);
    push_tick(1'b1, 16'd0, 8'd3);
    push_tick(1'b1, 16'hFFFF, 8'd6);
    settle();
    write_reg(adnv_pkg::REG_WINDOW_LEN, 16'd2);
    push_tick(1'b1, 16'd2049, 8'd1);
    settle();

    // spare indexes ignored; zero window and zero vote minimum give day
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    write_reg(adnv_pkg::REG_WINDOW_LEN, 16'd0);
    write_reg(adnv_pkg::REG_VOTE_MIN, 16'd0);
    push_tick(1'b1, 16'hFFFF, 8'd9);
    push_tick(1'b1, 16'hFFFF, 8'd8);
    settle();

    // random phases, first two at the register extremes
    for (p = 0; p < RandPhases; p++) begin
      if (p == 0) begin
        wlen = 4'd15;
        vmin = 4'd15;
      end else if (p == 1) begin
        wlen = 4'd1;
        vmin = 4'd1;
      end else begin
        wlen = 4'($urandom_range(1, 15));
        vmin = 4'($urandom_range(1, wlen));
      end
      write_reg(adnv_pkg::REG_THR_DAY_TO_LOW,
                (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0 : pick_thr());
      write_reg(adnv_pkg::REG_THR_LOW_TO_NIGHT,
                (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0 : pick_thr());
      write_reg(adnv_pkg::REG_THR_NIGHT_TO_DAY,
                (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0 : pick_thr());
      write_reg(adnv_pkg::REG_THR_LOW_TO_DAY,
                (p == 0) ? 16'hFFFF : (p == 1) ? 16'h0 : pick_thr());
      write_reg(adnv_pkg::REG_WINDOW_LEN, {12'($urandom), wlen});
      write_reg(adnv_pkg::REG_VOTE_MIN, {12'($urandom), vmin});
      idle_pct = (p % 3 == 2 || p == RandPhases - 1) ? 0 : 20;

      // windows of themed votes with some noise and ignored ticks
      enabled = 0;
      while (enabled < TicksPerPhase) begin
        theme = theme_t'($urandom_range(0, 3));
        for (k = 0; k < wlen; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            t = adnv_pkg::in_t'($urandom);
            t.auto_enable = 1'b0;
            tick_q.push_back(t);
          end
          t = rand_tick(($urandom_range(0, 4) == 0) ? THEME_NOISE : theme);
          tick_q.push_back(t);
          enabled++;
        end
      end
      settle();
    end

    if (decision_q.size() != 0) begin
      $error("%0d expected results never arrived", decision_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("auto_day_night_vote regression: pass");
    end else begin
      $display("auto_day_night_vote regression: fail");
    end
    $finish;
  end

endmodule
